[rtl/wfm_pkg.sv]
package wfm_pkg;

  // frame and transform geometry
  localparam int FftPoints = 64;
  localparam int AddrW     = 6;
  localparam int NumBins   = FftPoints / 2 + 1;
  localparam int LastBin   = FftPoints / 2;
  localparam int NumBf     = FftPoints / 2;
  localparam int NumStages = 6;
  localparam int SqrtIters = 24;
  localparam logic [21:0] MagMax = 22'h3FFFFF;

  localparam longint unsigned PiQ30  = 64'd3373259426;
  localparam longint unsigned OneQ30 = 64'd1073741824;

  // sequencer steps, shared by controller and datapath
  typedef enum logic [4:0] {
    OP_IDLE,
    OP_LD_RD,
    OP_LD_MUL,
    OP_LD_WR,
    OP_BF_RDA,
    OP_BF_RDB,
    OP_BF_M0,
    OP_BF_M1,
    OP_BF_M2,
    OP_BF_M3,
    OP_BF_M4,
    OP_BF_WRA,
    OP_BF_WRB,
    OP_MG_RD,
    OP_MG_SQ0,
    OP_MG_SQ1,
    OP_MG_SQ2,
    OP_MG_INIT,
    OP_MG_STEP,
    OP_MG_OUT
  } wfm_op_e;

  typedef struct packed {
    logic signed [23:0] re;
    logic signed [23:0] im;
  } cpx_t;

  typedef struct packed {
    wfm_op_e    op;
    logic [5:0] idx;
    logic [2:0] stage;
    logic       st_we;
    logic [5:0] st_addr;
    logic [6:0] eff_len;
  } wfm_cmd_t;

  typedef struct packed {
    logic out_free;
  } wfm_sts_t;

  typedef logic [FftPoints-1:0][16:0] win_tab_t;
  typedef logic [NumBf-1:0][16:0]     tw_tab_t;

  // cos(2 pi num / den) in signed q30, den is 63 for the window and 64 for twiddles
  function automatic longint cos_q30(input int unsigned num, input bit win);
    longint unsigned dn;
    longint unsigned n;
    longint unsigned m;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned sub;
    bit              neg;
    dn  = win ? 64'd63 : 64'd64;
    n   = 64'(num);
    neg = 1'b0;
    if (2 * n > dn) n = dn - n;
    if (4 * n > dn) begin
      neg = 1'b1;
      m   = dn - 2 * n;
    end else begin
      m = 2 * n;
    end
    if (win) x = (PiQ30 * m + 31) / 63;
    else     x = (PiQ30 * m + 32) / 64;
    x2  = (x * x + (OneQ30 >> 1)) >> 30;
    t   = OneQ30;
    sub = ((x2 * t) >> 30) / 182;
    t   = (sub > OneQ30) ? 64'd0 : OneQ30 - sub;
    sub = ((x2 * t) >> 30) / 132;
    t   = (sub > OneQ30) ? 64'd0 : OneQ30 - sub;
    sub = ((x2 * t) >> 30) / 90;
    t   = (sub > OneQ30) ? 64'd0 : OneQ30 - sub;
    sub = ((x2 * t) >> 30) / 56;
    t   = (sub > OneQ30) ? 64'd0 : OneQ30 - sub;
    sub = ((x2 * t) >> 30) / 30;
    t   = (sub > OneQ30) ? 64'd0 : OneQ30 - sub;
    sub = ((x2 * t) >> 30) / 12;
    t   = (sub > OneQ30) ? 64'd0 : OneQ30 - sub;
    sub = ((x2 * t) >> 30) / 2;
    t   = (sub > OneQ30) ? 64'd0 : OneQ30 - sub;
    return neg ? -longint'(t) : longint'(t);
  endfunction

  // round half up by 2^15
  function automatic longint rnd15(input longint v);
    return (v + 64'sd16384) >>> 15;
  endfunction

  function automatic win_tab_t build_win();
    win_tab_t tab;
    longint   c;
    longint   num;
    longint   w;
    for (int p = 0; p < FftPoints; p++) begin
      c   = cos_q30(p, 1'b1);
      num = 25 * longint'(OneQ30) - 21 * c;
      w   = (num + 23 * 32768) / (46 * 32768);
      if (w > 32767) w = 32767;
      tab[p] = 17'(w);
    end
    return tab;
  endfunction

  function automatic tw_tab_t build_tw_cos();
    tw_tab_t tab;
    for (int k = 0; k < NumBf; k++) begin
      tab[k] = 17'(rnd15(cos_q30(k, 1'b0)));
    end
    return tab;
  endfunction

  // imaginary twiddle part, already negated
  function automatic tw_tab_t build_tw_nsin();
    tw_tab_t tab;
    int      d;
    for (int k = 0; k < NumBf; k++) begin
      d      = (k > FftPoints / 4) ? k - FftPoints / 4 : FftPoints / 4 - k;
      tab[k] = 17'(-rnd15(cos_q30(d, 1'b0)));
    end
    return tab;
  endfunction

  localparam win_tab_t WinRom   = build_win();
  localparam tw_tab_t  TwCos    = build_tw_cos();
  localparam tw_tab_t  TwNegSin = build_tw_nsin();

  function automatic logic [AddrW-1:0] bitrev(input logic [AddrW-1:0] v);
    logic [AddrW-1:0] r;
    for (int i = 0; i < AddrW; i++) begin
      r[i] = v[AddrW-1-i];
    end
    return r;
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [28:0] v);
    if (v > 29'sd8388607) return 24'sd8388607;
    if (v < -29'sd8388608) return -24'sd8388608;
    return v[23:0];
  endfunction

endpackage

[rtl/windowed_fft_magnitude.sv]
// Hamming-windowed 64-point real FFT magnitude. Samples are taken one per
// transfer while the block is idle; when frame_length samples have arrived the
// frame is centered in the buffer, windowed and transformed, and 33 results
// (bins 0 to 32) follow, each with the truncated magnitude and the saturating
// per-bin energy sum kept since reset. A write to the frame length register
// drops any partial frame. Processing a full frame loads and windows all 64
// buffer entries, then runs the 192 butterflies on the one shared multiplier
// and the work memory, which has one write port and one read port, and then
// forms the squares and the 24-step bit-serial square root for each bin. No
// sample is taken during that time; output stalls lengthen it.
module windowed_fft_magnitude (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] sample_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [6:0]         cfg_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [5:0]         bin_index_o,
  output logic [21:0]        magnitude_o,
  output logic [31:0]        energy_total_o,
  output logic               last_bin_o
);
  import wfm_pkg::*;

  wfm_cmd_t cmd;
  wfm_sts_t sts;

  // sequencer
  wfm_ctl u_ctl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // memories and arithmetic
  wfm_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .sample_i      (sample_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .bin_index_o   (bin_index_o),
    .magnitude_o   (magnitude_o),
    .energy_total_o(energy_total_o),
    .last_bin_o    (last_bin_o)
  );

endmodule

[rtl/wfm_ram.sv]
module wfm_ram #(
  parameter int Width = 16,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/wfm_dp.sv]
module wfm_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  wfm_pkg::wfm_cmd_t cmd_i,
  output wfm_pkg::wfm_sts_t sts_o,
  input  logic signed [15:0] sample_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [5:0]        bin_index_o,
  output logic [21:0]       magnitude_o,
  output logic [31:0]       energy_total_o,
  output logic              last_bin_o
);
  import wfm_pkg::*;

  logic [15:0]        st_rdata;
  logic [AddrW-1:0]   st_raddr;
  cpx_t               wk_wdata;
  cpx_t               wk_rdata;
  logic               wk_we;
  logic [AddrW-1:0]   wk_waddr;
  logic [AddrW-1:0]   wk_raddr;
  logic [31:0]        en_rdata;
  logic               en_we;

  logic [6:0]         off;
  logic [6:0]         rel;
  logic               in_win;
  logic [4:0]         bf;
  logic [4:0]         jmask;
  logic [4:0]         jpart;
  logic [AddrW-1:0]   ia;
  logic [AddrW-1:0]   ib;
  logic [4:0]         ti;
  logic signed [16:0] tw_re;
  logic signed [16:0] tw_im;

  logic signed [23:0] ma;
  logic signed [23:0] mb;
  logic signed [47:0] prod_q;
  cpx_t               a_q;
  cpx_t               b_q;
  logic signed [48:0] acc_re_q;
  logic signed [48:0] acc_im_q;
  logic signed [48:0] t_re;
  logic signed [48:0] t_im;
  logic signed [28:0] t_re29;
  logic signed [28:0] t_im29;
  logic signed [47:0] ld_rnd;

  logic [31:0]        e_q;
  logic [NumBins-1:0] en_vld_q;
  logic [47:0]        sq_v_q;
  logic [47:0]        sq_r_q;
  logic [47:0]        sq_bit_q;
  logic [48:0]        sq_trial;

  logic [21:0]        mag;
  logic [32:0]        sum33;
  logic [31:0]        esum;
  logic               out_free;
  logic               out_load;
  logic               out_valid_q;

  // memories
  wfm_ram #(.Width(16), .Depth(FftPoints)) u_store (
    .clk_i  (clk_i),
    .we_i   (cmd_i.st_we),
    .waddr_i(cmd_i.st_addr),
    .wdata_i(sample_i),
    .raddr_i(st_raddr),
    .rdata_o(st_rdata)
  );

  wfm_ram #(.Width(48), .Depth(FftPoints)) u_work (
    .clk_i  (clk_i),
    .we_i   (wk_we),
    .waddr_i(wk_waddr),
    .wdata_i(wk_wdata),
    .raddr_i(wk_raddr),
    .rdata_o(wk_rdata)
  );

  wfm_ram #(.Width(32), .Depth(NumBins)) u_energy (
    .clk_i  (clk_i),
    .we_i   (en_we),
    .waddr_i(cmd_i.idx),
    .wdata_i(esum),
    .raddr_i(cmd_i.idx),
    .rdata_o(en_rdata)
  );

  // frame placement inside the buffer
  assign off      = (7'(FftPoints) - cmd_i.eff_len) >> 1;
  assign rel      = {1'b0, cmd_i.idx} - off;
  assign in_win   = ({1'b0, cmd_i.idx} >= off) && (rel < cmd_i.eff_len);
  assign st_raddr = rel[AddrW-1:0];

  // butterfly addresses and twiddle index
  assign bf    = cmd_i.idx[4:0];
  assign jmask = 5'((6'd1 << cmd_i.stage) - 6'd1);
  assign jpart = bf & jmask;
  assign ia    = 6'(({1'b0, bf} >> cmd_i.stage) << (cmd_i.stage + 3'd1)) | {1'b0, jpart};
  assign ib    = ia | 6'(6'd1 << cmd_i.stage);
  assign ti    = 5'(jpart << (3'd5 - cmd_i.stage));
  assign tw_re = $signed(TwCos[ti]);
  assign tw_im = $signed(TwNegSin[ti]);

  // shared multiplier operands
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd_i.op)
      OP_LD_MUL: begin
        ma = 24'($signed(st_rdata));
        mb = 24'($signed(WinRom[cmd_i.idx]));
      end
      OP_BF_M0: begin
        ma = wk_rdata.re;
        mb = 24'(tw_re);
      end
      OP_BF_M1: begin
        ma = b_q.im;
        mb = 24'(tw_im);
      end
      OP_BF_M2: begin
        ma = b_q.re;
        mb = 24'(tw_im);
      end
      OP_BF_M3: begin
        ma = b_q.im;
        mb = 24'(tw_re);
      end
      OP_MG_SQ0: begin
        ma = wk_rdata.re;
        mb = wk_rdata.re;
      end
      OP_MG_SQ1: begin
        ma = b_q.im;
        mb = b_q.im;
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  // rounded products and butterfly sums
  assign ld_rnd = (prod_q + 48'sd16384) >>> 15;
  assign t_re   = (acc_re_q + 49'sd16384) >>> 15;
  assign t_im   = (acc_im_q + 49'sd16384) >>> 15;
  assign t_re29 = t_re[28:0];
  assign t_im29 = t_im[28:0];

  // work memory access
  always_comb begin
    wk_we    = 1'b0;
    wk_waddr = bitrev(cmd_i.idx);
    wk_wdata = '0;
    wk_raddr = cmd_i.idx;
    case (cmd_i.op)
      OP_LD_WR: begin
        wk_we       = 1'b1;
        wk_wdata.re = in_win ? ld_rnd[23:0] : 24'sd0;
      end
      OP_BF_RDA: wk_raddr = ia;
      OP_BF_RDB: wk_raddr = ib;
      OP_BF_WRA: begin
        wk_we       = 1'b1;
        wk_waddr    = ia;
        wk_wdata.re = sat24(29'(a_q.re) + t_re29);
        wk_wdata.im = sat24(29'(a_q.im) + t_im29);
      end
      OP_BF_WRB: begin
        wk_we       = 1'b1;
        wk_waddr    = ib;
        wk_wdata.re = sat24(29'(a_q.re) - t_re29);
        wk_wdata.im = sat24(29'(a_q.im) - t_im29);
      end
      default: wk_we = 1'b0;
    endcase
  end

  // arithmetic registers
  always_ff @(posedge clk_i) begin
    prod_q <= ma * mb;
    case (cmd_i.op)
      OP_BF_RDB: a_q <= wk_rdata;
      OP_BF_M0:  b_q <= wk_rdata;
      OP_BF_M1:  acc_re_q <= 49'(prod_q);
      OP_BF_M2:  acc_re_q <= acc_re_q - 49'(prod_q);
      OP_BF_M3:  acc_im_q <= 49'(prod_q);
      OP_BF_M4:  acc_im_q <= acc_im_q + 49'(prod_q);
      OP_MG_SQ0: begin
        b_q <= wk_rdata;
        e_q <= en_vld_q[cmd_i.idx] ? en_rdata : 32'd0;
      end
      OP_MG_SQ1: acc_re_q <= 49'(prod_q);
      OP_MG_SQ2: acc_re_q <= acc_re_q + 49'(prod_q);
      OP_MG_INIT: begin
        sq_v_q   <= acc_re_q[47:0];
        sq_r_q   <= '0;
        sq_bit_q <= 48'h1 << 46;
      end
      OP_MG_STEP: begin
        if ({1'b0, sq_v_q} >= sq_trial) begin
          sq_v_q <= sq_v_q - sq_trial[47:0];
          sq_r_q <= (sq_r_q >> 1) + sq_bit_q;
        end else begin
          sq_r_q <= sq_r_q >> 1;
        end
        sq_bit_q <= sq_bit_q >> 2;
      end
      default: ;
    endcase
  end

  assign sq_trial = {1'b0, sq_r_q} + {1'b0, sq_bit_q};

  // magnitude and saturating energy
  assign mag   = (sq_r_q[47:22] != '0) ? MagMax : sq_r_q[21:0];
  assign sum33 = {1'b0, e_q} + 33'(mag);
  assign esum  = sum33[32] ? 32'hFFFF_FFFF : sum33[31:0];

  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = (cmd_i.op == OP_MG_OUT) && out_free;
  assign en_we    = out_load;
  assign sts_o.out_free = out_free;

  // energy entry valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_vld_q <= '0;
    end else if (en_we) begin
      en_vld_q[cmd_i.idx] <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      bin_index_o    <= cmd_i.idx;
      magnitude_o    <= mag;
      energy_total_o <= esum;
      last_bin_o     <= (cmd_i.idx == 6'(LastBin));
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[rtl/wfm_ctl.sv]
module wfm_ctl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [6:0]        cfg_data_i,
  input  wfm_pkg::wfm_sts_t sts_i,
  output wfm_pkg::wfm_cmd_t cmd_o
);
  import wfm_pkg::*;

  wfm_op_e    state_q, state_d;
  logic [5:0] idx_q, idx_d;
  logic [2:0] stage_q, stage_d;
  logic [4:0] iter_q, iter_d;
  logic [6:0] loaded_q, loaded_d;
  logic [6:0] flen_q, flen_d;
  logic [6:0] eff_len;
  logic       st_we;

  // effective frame length
  always_comb begin
    if (flen_q == 7'd0)               eff_len = 7'd1;
    else if (flen_q > 7'(FftPoints)) eff_len = 7'(FftPoints);
    else                              eff_len = flen_q;
  end

  // state and counter registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= OP_IDLE;
      idx_q    <= '0;
      stage_q  <= '0;
      iter_q   <= '0;
      loaded_q <= '0;
      flen_q   <= 7'(FftPoints);
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      stage_q  <= stage_d;
      iter_q   <= iter_d;
      loaded_q <= loaded_d;
      flen_q   <= flen_d;
    end
  end

  // next state and handshakes
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    stage_d     = stage_q;
    iter_d      = iter_q;
    loaded_d    = loaded_q;
    flen_d      = flen_q;
    in_stall_o  = 1'b1;
    cfg_ready_o = 1'b0;
    st_we       = 1'b0;
    case (state_q)
      OP_IDLE: begin
        cfg_ready_o = 1'b1;
        in_stall_o  = cfg_valid_i;
        if (cfg_valid_i) begin
          flen_d   = cfg_data_i;
          loaded_d = '0;
        end else if (in_valid_i) begin
          st_we = 1'b1;
          if (loaded_q + 7'd1 >= eff_len) begin
            loaded_d = '0;
            idx_d    = '0;
            state_d  = OP_LD_RD;
          end else begin
            loaded_d = loaded_q + 7'd1;
          end
        end
      end
      OP_LD_RD:  state_d = OP_LD_MUL;
      OP_LD_MUL: state_d = OP_LD_WR;
      OP_LD_WR: begin
        if (idx_q == 6'(FftPoints - 1)) begin
          idx_d   = '0;
          stage_d = '0;
          state_d = OP_BF_RDA;
        end else begin
          idx_d   = idx_q + 6'd1;
          state_d = OP_LD_RD;
        end
      end
      OP_BF_RDA: state_d = OP_BF_RDB;
      OP_BF_RDB: state_d = OP_BF_M0;
      OP_BF_M0:  state_d = OP_BF_M1;
      OP_BF_M1:  state_d = OP_BF_M2;
      OP_BF_M2:  state_d = OP_BF_M3;
      OP_BF_M3:  state_d = OP_BF_M4;
      OP_BF_M4:  state_d = OP_BF_WRA;
      OP_BF_WRA: state_d = OP_BF_WRB;
      OP_BF_WRB: begin
        state_d = OP_BF_RDA;
        if (idx_q == 6'(NumBf - 1)) begin
          idx_d = '0;
          if (stage_q == 3'(NumStages - 1)) begin
            state_d = OP_MG_RD;
          end else begin
            stage_d = stage_q + 3'd1;
          end
        end else begin
          idx_d = idx_q + 6'd1;
        end
      end
      OP_MG_RD:   state_d = OP_MG_SQ0;
      OP_MG_SQ0:  state_d = OP_MG_SQ1;
      OP_MG_SQ1:  state_d = OP_MG_SQ2;
      OP_MG_SQ2:  state_d = OP_MG_INIT;
      OP_MG_INIT: begin
        iter_d  = '0;
        state_d = OP_MG_STEP;
      end
      OP_MG_STEP: begin
        if (iter_q == 5'(SqrtIters - 1)) begin
          state_d = OP_MG_OUT;
        end else begin
          iter_d = iter_q + 5'd1;
        end
      end
      OP_MG_OUT: begin
        if (sts_i.out_free) begin
          if (idx_q == 6'(LastBin)) begin
            idx_d   = '0;
            state_d = OP_IDLE;
          end else begin
            idx_d   = idx_q + 6'd1;
            state_d = OP_MG_RD;
          end
        end
      end
      default: state_d = OP_IDLE;
    endcase
  end

  assign cmd_o.op      = state_q;
  assign cmd_o.idx     = idx_q;
  assign cmd_o.stage   = stage_q;
  assign cmd_o.st_we   = st_we;
  assign cmd_o.st_addr = loaded_q[5:0];
  assign cmd_o.eff_len = eff_len;

  a_bin_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == OP_MG_OUT |-> idx_q <= 6'(LastBin))
    else $error("bin counter past last bin");

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    loaded_q < eff_len)
    else $error("fill count reached frame length");

  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |-> state_q == OP_IDLE && !cfg_valid_i)
    else $error("sample taken while busy");

  a_fft_to_mag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == OP_BF_WRB && idx_q == 6'(NumBf - 1) && stage_q == 3'(NumStages - 1)
    |=> state_q == OP_MG_RD && idx_q == 6'd0)
    else $error("transform end did not start bin output");

endmodule
